// ===== src/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// grr_pkg
// Types, constants and the 5x7 glyph ROM shared by the glyph rectangle renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

  localparam int SCREEN_WIDTH  = 384;
  localparam int SCREEN_HEIGHT = 216;
  localparam int MAX_STRING    = 64;
  localparam int ADV_CAP       = 12;
  localparam int GLYPH_CELLS   = 35;
  localparam int DIV_STEPS     = 10;
  localparam int X_MOD         = 5;
  localparam int Y_MOD         = 7;
  // floor(v/7) = (v*RECIP7)>>16 for v below 1024
  localparam int RECIP7        = 9363;

  localparam logic [2:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [2:0] CFG_CLIP_TOP    = 3'd1;
  localparam logic [2:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [2:0] CFG_CLIP_BOTTOM = 3'd3;

  typedef logic [34:0] glyph_t;
  typedef logic signed [15:0] coord_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_CALC1,
    F_CALC2
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [8:0] left;
    logic [7:0] top;
    logic [8:0] right;
    logic [7:0] bottom;
  } clip_t;

  typedef struct packed {
    glyph_t      glyph;
    coord_t      x_base;
    coord_t      y_base;
    logic [3:0]  xq;
    logic [2:0]  xr;
    logic [7:0]  yq;
    logic [2:0]  yr;
    logic [15:0] color;
  } job_t;

  typedef struct packed {
    logic [8:0]  x_start;
    logic [7:0]  y_start;
    logic [8:0]  x_end;
    logic [7:0]  y_end;
    logic [15:0] fill_color;
    logic        last;
  } rect_t;

  // Rows top to bottom, leftmost column in the msb of each row.
  function automatic glyph_t glyph_rows(input logic [7:0] code);
    glyph_t g;
    case (code)
      8'h41: g = {5'd14,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17};
      8'h42: g = {5'd30,5'd17,5'd17,5'd30,5'd17,5'd17,5'd30};
      8'h43: g = {5'd14,5'd17,5'd16,5'd16,5'd16,5'd17,5'd14};
      8'h44: g = {5'd30,5'd17,5'd17,5'd17,5'd17,5'd17,5'd30};
      8'h45: g = {5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd31};
      8'h46: g = {5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd16};
      8'h47: g = {5'd14,5'd17,5'd16,5'd23,5'd17,5'd17,5'd15};
      8'h48: g = {5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17};
      8'h49: g = {5'd14,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14};
      8'h4A: g = {5'd7,5'd2,5'd2,5'd2,5'd18,5'd18,5'd12};
      8'h4B: g = {5'd17,5'd18,5'd20,5'd24,5'd20,5'd18,5'd17};
      8'h4C: g = {5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd31};
      8'h4D: g = {5'd17,5'd27,5'd21,5'd21,5'd17,5'd17,5'd17};
      8'h4E: g = {5'd17,5'd25,5'd21,5'd19,5'd17,5'd17,5'd17};
      8'h4F: g = {5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14};
      8'h50: g = {5'd30,5'd17,5'd17,5'd30,5'd16,5'd16,5'd16};
      8'h51: g = {5'd14,5'd17,5'd17,5'd17,5'd21,5'd18,5'd13};
      8'h52: g = {5'd30,5'd17,5'd17,5'd30,5'd20,5'd18,5'd17};
      8'h53: g = {5'd15,5'd16,5'd16,5'd14,5'd1,5'd1,5'd30};
      8'h54: g = {5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4};
      8'h55: g = {5'd17,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14};
      8'h56: g = {5'd17,5'd17,5'd17,5'd17,5'd17,5'd10,5'd4};
      8'h57: g = {5'd17,5'd17,5'd17,5'd21,5'd21,5'd21,5'd10};
      8'h58: g = {5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17};
      8'h59: g = {5'd17,5'd17,5'd10,5'd4,5'd4,5'd4,5'd4};
      8'h5A: g = {5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd31};
      8'h61: g = {5'd0,5'd0,5'd14,5'd1,5'd15,5'd17,5'd15};
      8'h62: g = {5'd16,5'd16,5'd30,5'd17,5'd17,5'd17,5'd30};
      8'h63: g = {5'd0,5'd0,5'd14,5'd16,5'd16,5'd17,5'd14};
      8'h64: g = {5'd1,5'd1,5'd15,5'd17,5'd17,5'd17,5'd15};
      8'h65: g = {5'd0,5'd0,5'd14,5'd17,5'd31,5'd16,5'd14};
      8'h66: g = {5'd6,5'd9,5'd8,5'd28,5'd8,5'd8,5'd8};
      8'h67: g = {5'd0,5'd0,5'd15,5'd17,5'd15,5'd1,5'd14};
      8'h68: g = {5'd16,5'd16,5'd30,5'd17,5'd17,5'd17,5'd17};
      8'h69: g = {5'd4,5'd0,5'd12,5'd4,5'd4,5'd4,5'd14};
      8'h6A: g = {5'd2,5'd0,5'd6,5'd2,5'd2,5'd18,5'd12};
      8'h6B: g = {5'd16,5'd16,5'd18,5'd20,5'd24,5'd20,5'd18};
      8'h6C: g = {5'd12,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14};
      8'h6D: g = {5'd0,5'd0,5'd26,5'd21,5'd21,5'd21,5'd21};
      8'h6E: g = {5'd0,5'd0,5'd30,5'd17,5'd17,5'd17,5'd17};
      8'h6F: g = {5'd0,5'd0,5'd14,5'd17,5'd17,5'd17,5'd14};
      8'h70: g = {5'd0,5'd0,5'd30,5'd17,5'd30,5'd16,5'd16};
      8'h71: g = {5'd0,5'd0,5'd15,5'd17,5'd15,5'd1,5'd1};
      8'h72: g = {5'd0,5'd0,5'd22,5'd25,5'd16,5'd16,5'd16};
      8'h73: g = {5'd0,5'd0,5'd15,5'd16,5'd14,5'd1,5'd30};
      8'h74: g = {5'd8,5'd8,5'd28,5'd8,5'd8,5'd9,5'd6};
      8'h75: g = {5'd0,5'd0,5'd17,5'd17,5'd17,5'd19,5'd13};
      8'h76: g = {5'd0,5'd0,5'd17,5'd17,5'd17,5'd10,5'd4};
      8'h77: g = {5'd0,5'd0,5'd17,5'd17,5'd21,5'd21,5'd10};
      8'h78: g = {5'd0,5'd0,5'd17,5'd10,5'd4,5'd10,5'd17};
      8'h79: g = {5'd0,5'd0,5'd17,5'd17,5'd15,5'd1,5'd14};
      8'h7A: g = {5'd0,5'd0,5'd31,5'd2,5'd4,5'd8,5'd31};
      8'h30: g = {5'd14,5'd17,5'd19,5'd21,5'd25,5'd17,5'd14};
      8'h31: g = {5'd4,5'd12,5'd4,5'd4,5'd4,5'd4,5'd14};
      8'h32: g = {5'd14,5'd17,5'd1,5'd2,5'd4,5'd8,5'd31};
      8'h33: g = {5'd30,5'd1,5'd1,5'd14,5'd1,5'd1,5'd30};
      8'h34: g = {5'd2,5'd6,5'd10,5'd18,5'd31,5'd2,5'd2};
      8'h35: g = {5'd31,5'd16,5'd16,5'd30,5'd1,5'd1,5'd30};
      8'h36: g = {5'd6,5'd8,5'd16,5'd30,5'd17,5'd17,5'd14};
      8'h37: g = {5'd31,5'd1,5'd2,5'd4,5'd8,5'd8,5'd8};
      8'h38: g = {5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14};
      8'h39: g = {5'd14,5'd17,5'd17,5'd15,5'd1,5'd2,5'd12};
      8'h2B: g = {5'd0,5'd4,5'd4,5'd31,5'd4,5'd4,5'd0};
      8'h2D: g = {5'd0,5'd0,5'd0,5'd31,5'd0,5'd0,5'd0};
      8'h3D: g = {5'd0,5'd0,5'd31,5'd0,5'd31,5'd0,5'd0};
      8'h2A: g = {5'd0,5'd17,5'd10,5'd4,5'd10,5'd17,5'd0};
      8'h2F: g = {5'd1,5'd1,5'd2,5'd4,5'd8,5'd16,5'd16};
      8'h1F: g = {5'd4,5'd0,5'd0,5'd31,5'd0,5'd0,5'd4};
      8'h1E: g = {5'd0,5'd31,5'd10,5'd10,5'd10,5'd10,5'd18};
      8'h1D: g = {5'd0,5'd15,5'd18,5'd18,5'd18,5'd12,5'd0};
      8'h1A: g = {5'd0,5'd4,5'd2,5'd31,5'd2,5'd4,5'd0};
      8'h1C: g = {5'd14,5'd17,5'd17,5'd31,5'd17,5'd17,5'd14};
      8'h1B: g = {5'd0,5'd2,5'd4,5'd8,5'd16,5'd31,5'd0};
      8'h2E: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd6,5'd6};
      8'h2C: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd6,5'd4};
      8'h3A: g = {5'd0,5'd4,5'd4,5'd0,5'd4,5'd4,5'd0};
      8'h3B: g = {5'd0,5'd4,5'd4,5'd0,5'd4,5'd4,5'd8};
      8'h28: g = {5'd2,5'd4,5'd8,5'd8,5'd8,5'd4,5'd2};
      8'h29: g = {5'd8,5'd4,5'd2,5'd2,5'd2,5'd4,5'd8};
      8'h5B: g = {5'd14,5'd8,5'd8,5'd8,5'd8,5'd8,5'd14};
      8'h5D: g = {5'd14,5'd2,5'd2,5'd2,5'd2,5'd2,5'd14};
      8'h3C: g = {5'd0,5'd2,5'd4,5'd8,5'd4,5'd2,5'd0};
      8'h3E: g = {5'd0,5'd8,5'd4,5'd2,5'd4,5'd8,5'd0};
      8'h5E: g = {5'd4,5'd10,5'd17,5'd0,5'd0,5'd0,5'd0};
      8'h5F: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd31};
      8'h7C: g = {5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4};
      8'h21: g = {5'd4,5'd4,5'd4,5'd4,5'd0,5'd4,5'd0};
      8'h3F: g = {5'd14,5'd17,5'd2,5'd4,5'd0,5'd4,5'd0};
      8'h27: g = {5'd4,5'd4,5'd0,5'd0,5'd0,5'd0,5'd0};
      8'h22: g = {5'd10,5'd10,5'd0,5'd0,5'd0,5'd0,5'd0};
      8'h25: g = {5'd25,5'd26,5'd2,5'd4,5'd8,5'd11,5'd19};
      8'h26: g = {5'd12,5'd18,5'd20,5'd8,5'd21,5'd18,5'd13};
      8'h20: g = '0;
      default: g = {5'd31,5'd17,5'd0,5'd4,5'd0,5'd17,5'd31};
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== src/grr_front.sv =====
// ----------------------------------------------------------------------------
// grr_front
// Accepts a character, looks up its glyph and works out the cell geometry.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_front
  import grr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_kind,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [5:0]         in_char_index,
  input  wire logic [6:0]         in_char_count,
  input  wire logic signed [10:0] in_origin_x,
  input  wire logic signed [10:0] in_origin_y,
  input  wire logic [3:0]         in_scale,
  input  wire logic [9:0]         in_box_width,
  input  wire logic [9:0]         in_box_height,
  input  wire logic [15:0]        in_color,
  output logic                    jq_push,
  output job_t                    jq_din,
  input  wire logic               jq_full
);

  front_state_t state_r, state_nxt;

  logic               kind_r;
  glyph_t             glyph_r;
  logic [5:0]         idx_r;
  logic [6:0]         cnt_r;
  logic signed [10:0] ox_r, oy_r;
  logic [3:0]         scale_r;
  logic [9:0]         bw_r, bh_r;
  logic [15:0]        color_r;

  logic [6:0]  div_rem_r;
  logic [9:0]  div_q_r;
  logic [3:0]  div_cnt_r;

  logic [3:0]  adv_r;
  logic [10:0] p_cnt_adv_r;
  logic [9:0]  p_idx_adv_r;
  logic [9:0]  p_idx_sc_r;
  logic [7:0]  yq_r;

  logic        accept;
  logic [6:0]  cnt_c;
  logic [7:0]  rem_sh;
  logic        ge;
  logic [3:0]  adv_c;
  logic [23:0] bh_prod;

  logic [3:0]  gw;
  logic [3:0]  xq_l;
  logic [12:0] p6;
  logic [10:0] half_sum;
  logic [10:0] yr_full;
  coord_t      ox16, oy16;

  assign accept = in_push && !in_full;
  assign cnt_c  = (in_char_count > 7'(MAX_STRING)) ? 7'(MAX_STRING) : in_char_count;

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {div_rem_r, div_q_r[9]};
  assign ge     = rem_sh >= {1'b0, cnt_r};

  assign adv_c   = (div_q_r > 10'(ADV_CAP)) ? 4'(ADV_CAP) : div_q_r[3:0];
  assign bh_prod = bh_r * 14'(RECIP7);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = (in_kind && cnt_c != 7'd0) ? F_DIV : F_CALC1;
      end
      F_DIV: begin
        if (div_cnt_r == 4'(DIV_STEPS - 1)) state_nxt = F_CALC1;
      end
      F_CALC1: state_nxt = F_CALC2;
      F_CALC2: begin
        if (!jq_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_full = (state_r != F_IDLE);
    jq_push = (state_r == F_CALC2) && !jq_full;
  end

  always_comb begin
    ox16     = coord_t'(ox_r);
    oy16     = coord_t'(oy_r);
    gw       = (adv_r < 4'd7) ? 4'd5 : adv_r - 4'd2;
    xq_l     = (gw == 4'd10) ? 4'd2 : 4'd1;
    p6       = {1'b0, p_idx_sc_r, 2'b00} + {2'b00, p_idx_sc_r, 1'b0};
    half_sum = {1'b0, bw_r} + 11'd2 - p_cnt_adv_r;
    yr_full  = {1'b0, bh_r} - ({yq_r, 3'b000} - {3'b000, yq_r});

    jq_din.glyph  = glyph_r;
    jq_din.y_base = oy16;
    jq_din.color  = color_r;
    if (kind_r) begin
      jq_din.x_base = ox16 + coord_t'({6'd0, half_sum[10:1]}) + coord_t'({6'd0, p_idx_adv_r});
      jq_din.xq     = xq_l;
      jq_din.xr     = 3'(gw - (xq_l * 4'(X_MOD)));
      jq_din.yq     = yq_r;
      jq_din.yr     = yr_full[2:0];
    end else begin
      jq_din.x_base = ox16 + coord_t'({3'd0, p6});
      jq_din.xq     = scale_r;
      jq_din.xr     = 3'd0;
      jq_din.yq     = {4'd0, scale_r};
      jq_din.yr     = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_kind;
      glyph_r   <= (in_kind && cnt_c == 7'd0) ? '0 : glyph_rows(in_char_code);
      idx_r     <= in_char_index;
      cnt_r     <= cnt_c;
      ox_r      <= in_origin_x;
      oy_r      <= in_origin_y;
      scale_r   <= in_scale;
      bw_r      <= in_box_width;
      bh_r      <= in_box_height;
      color_r   <= in_color;
      div_rem_r <= '0;
      div_q_r   <= in_box_width;
      div_cnt_r <= '0;
    end else if (state_r == F_DIV) begin
      div_rem_r <= ge ? 7'(rem_sh - {1'b0, cnt_r}) : rem_sh[6:0];
      div_q_r   <= {div_q_r[8:0], ge};
      div_cnt_r <= div_cnt_r + 4'd1;
    end
    if (state_r == F_CALC1) begin
      adv_r       <= adv_c;
      p_cnt_adv_r <= cnt_r * adv_c;
      p_idx_adv_r <= idx_r * adv_c;
      p_idx_sc_r  <= idx_r * scale_r;
      yq_r        <= bh_prod[23:16];
    end
  end

endmodule

`default_nettype wire

// ===== src/grr_jobq.sv =====
// ----------------------------------------------------------------------------
// grr_jobq
// Two-entry queue of prepared glyph jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_jobq
  import grr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      din,
  output logic      full,
  input  wire logic pop,
  output job_t      dout,
  output logic      empty
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

`default_nettype wire

// ===== src/grr_back.sv =====
// ----------------------------------------------------------------------------
// grr_back
// Walks the 35 glyph cells, clips each lit cell and queues the rectangles.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_back
  import grr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  clip_t      clip,
  input  job_t       jq_dout,
  input  wire logic  jq_empty,
  output logic       jq_pop,
  output logic       out_empty,
  input  wire logic  out_pop,
  output rect_t      out_rect
);

  back_state_t state_r, state_nxt;

  glyph_t      bits_r;
  logic [5:0]  cell_cnt_r;
  logic [2:0]  col_r;
  coord_t      x_base_r;
  logic [3:0]  xq_r;
  logic [2:0]  xr_r;
  logic [7:0]  yq_r;
  logic [2:0]  yr_r;
  logic [15:0] color_r;
  coord_t      x_lo_r, x_hi_r, y_lo_r, y_hi_r;
  logic [2:0]  x_rem_r, y_rem_r;
  rect_t       pend_r;
  logic        pend_vld_r;

  rect_t       of_mem_r [2];
  logic        of_wr_r, of_rd_r;
  logic [1:0]  of_cnt_r;
  logic        of_full, of_push, of_pop;
  rect_t       of_din;

  coord_t      cl16, ct16, cr16, cb16;
  coord_t      x0c, x1c, y0c, y1c;
  logic        emit, stall, advance;
  rect_t       cur_rect;

  logic [3:0]  xs, ys;
  coord_t      x_hi_nxt, y_hi_nxt;
  logic [2:0]  x_rem_nxt, y_rem_nxt;

  // clip window, right and bottom held to the screen
  always_comb begin
    cl16 = coord_t'({7'd0, clip.left});
    ct16 = coord_t'({8'd0, clip.top});
    cr16 = (clip.right > 9'(SCREEN_WIDTH)) ? coord_t'(SCREEN_WIDTH)
                                           : coord_t'({7'd0, clip.right});
    cb16 = (clip.bottom > 8'(SCREEN_HEIGHT)) ? coord_t'(SCREEN_HEIGHT)
                                             : coord_t'({8'd0, clip.bottom});
    x0c  = (x_lo_r < cl16) ? cl16 : x_lo_r;
    y0c  = (y_lo_r < ct16) ? ct16 : y_lo_r;
    x1c  = (x_hi_r > cr16) ? cr16 : x_hi_r;
    y1c  = (y_hi_r > cb16) ? cb16 : y_hi_r;
    cur_rect.x_start    = x0c[8:0];
    cur_rect.y_start    = y0c[7:0];
    cur_rect.x_end      = x1c[8:0];
    cur_rect.y_end      = y1c[7:0];
    cur_rect.fill_color = color_r;
    cur_rect.last       = 1'b0;
  end

  // next cell edge: step by quotient, carry the remainder
  always_comb begin
    xs = {1'b0, x_rem_r} + {1'b0, xr_r};
    ys = {1'b0, y_rem_r} + {1'b0, yr_r};
    if (xs >= 4'(X_MOD)) begin
      x_hi_nxt  = x_hi_r + coord_t'({12'd0, xq_r}) + 16'sd1;
      x_rem_nxt = 3'(xs - 4'(X_MOD));
    end else begin
      x_hi_nxt  = x_hi_r + coord_t'({12'd0, xq_r});
      x_rem_nxt = xs[2:0];
    end
    if (ys >= 4'(Y_MOD)) begin
      y_hi_nxt  = y_hi_r + coord_t'({8'd0, yq_r}) + 16'sd1;
      y_rem_nxt = 3'(ys - 4'(Y_MOD));
    end else begin
      y_hi_nxt  = y_hi_r + coord_t'({8'd0, yq_r});
      y_rem_nxt = ys[2:0];
    end
  end

  always_comb begin
    emit    = bits_r[34] && (x0c < x1c) && (y0c < y1c);
    jq_pop  = 1'b0;
    of_push = 1'b0;
    of_din  = pend_r;
    stall   = 1'b0;
    case (state_r)
      B_IDLE: jq_pop = !jq_empty;
      B_WALK: begin
        stall   = emit && pend_vld_r && of_full;
        of_push = emit && pend_vld_r && !of_full;
      end
      B_FLUSH: begin
        of_push     = pend_vld_r && !of_full;
        of_din.last = 1'b1;
      end
      default: ;
    endcase
    advance = (state_r == B_WALK) && !stall;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!jq_empty) state_nxt = B_WALK;
      end
      B_WALK: begin
        if (advance && cell_cnt_r == 6'(GLYPH_CELLS - 1)) state_nxt = B_FLUSH;
      end
      B_FLUSH: begin
        if (!pend_vld_r || !of_full) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      pend_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance && emit) begin
        pend_vld_r <= 1'b1;
      end else if (state_r == B_FLUSH && state_nxt == B_IDLE) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (jq_pop) begin
      bits_r     <= jq_dout.glyph;
      cell_cnt_r <= '0;
      col_r      <= '0;
      x_base_r   <= jq_dout.x_base;
      xq_r       <= jq_dout.xq;
      xr_r       <= jq_dout.xr;
      yq_r       <= jq_dout.yq;
      yr_r       <= jq_dout.yr;
      color_r    <= jq_dout.color;
      x_lo_r     <= jq_dout.x_base;
      x_hi_r     <= jq_dout.x_base + coord_t'({12'd0, jq_dout.xq});
      x_rem_r    <= jq_dout.xr;
      y_lo_r     <= jq_dout.y_base;
      y_hi_r     <= jq_dout.y_base + coord_t'({8'd0, jq_dout.yq});
      y_rem_r    <= jq_dout.yr;
    end else if (advance) begin
      bits_r     <= {bits_r[33:0], 1'b0};
      cell_cnt_r <= cell_cnt_r + 6'd1;
      if (emit) pend_r <= cur_rect;
      if (col_r == 3'(X_MOD - 1)) begin
        col_r   <= '0;
        x_lo_r  <= x_base_r;
        x_hi_r  <= x_base_r + coord_t'({12'd0, xq_r});
        x_rem_r <= xr_r;
        y_lo_r  <= y_hi_r;
        y_hi_r  <= y_hi_nxt;
        y_rem_r <= y_rem_nxt;
      end else begin
        col_r   <= col_r + 3'd1;
        x_lo_r  <= x_hi_r;
        x_hi_r  <= x_hi_nxt;
        x_rem_r <= x_rem_nxt;
      end
    end
  end

  // result queue
  assign of_full   = (of_cnt_r == 2'd2);
  assign out_empty = (of_cnt_r == 2'd0);
  assign of_pop    = out_pop && !out_empty;
  assign out_rect  = of_mem_r[of_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r  <= 1'b0;
      of_rd_r  <= 1'b0;
      of_cnt_r <= 2'd0;
    end else begin
      if (of_push) of_wr_r <= ~of_wr_r;
      if (of_pop)  of_rd_r <= ~of_rd_r;
      of_cnt_r <= of_cnt_r + {1'b0, of_push} - {1'b0, of_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (of_push) of_mem_r[of_wr_r] <= of_din;
  end

  a_of_bound: assert property (@(posedge clk) disable iff (!rst_n)
    of_cnt_r != 2'd3) else $error("result queue overflow");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_IDLE |-> !pend_vld_r) else $error("rectangle left pending");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_WALK && stall) |=> $stable(cell_cnt_r) && $stable(pend_r))
    else $error("walker moved while stalled");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FLUSH && of_push) |-> of_din.last) else $error("flush without last");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_WALK |-> col_r < 3'(X_MOD)) else $error("column out of range");

endmodule

`default_nettype wire

// ===== src/glyph_rect_renderer.sv =====
// ----------------------------------------------------------------------------
// glyph_rect_renderer
// 5x7 character generator that turns lit glyph cells into clipped rectangles.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in_*      input      push / full          kind, char, position, geometry, color
// out_*     output     pop / empty          clipped rectangle, color, last
// cfg_*     input      valid / ready        register index, data
//
// Front: accepts an item, runs the divider in label mode, then the geometry states.
// Back: walks the 35 cells of each glyph, then a flush state; the walker takes
// one cell a cycle unless the result queue is full.
// The front prepares the next item while the back walks the current one.
// A full result queue stalls the walker; reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_rect_renderer
  import grr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_kind,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [5:0]         in_char_index,
  input  wire logic [6:0]         in_char_count,
  input  wire logic signed [10:0] in_origin_x,
  input  wire logic signed [10:0] in_origin_y,
  input  wire logic [3:0]         in_scale,
  input  wire logic [9:0]         in_box_width,
  input  wire logic [9:0]         in_box_height,
  input  wire logic [15:0]        in_color,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [8:0]              out_x_start,
  output logic [7:0]              out_y_start,
  output logic [8:0]              out_x_end,
  output logic [7:0]              out_y_end,
  output logic [15:0]             out_fill_color,
  output logic                    out_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [8:0]         cfg_data
);

  clip_t clip_r;
  job_t  jq_din, jq_dout;
  logic  jq_push, jq_full, jq_pop, jq_empty;
  rect_t out_rect;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r.left   <= 9'd0;
      clip_r.top    <= 8'd0;
      clip_r.right  <= 9'(SCREEN_WIDTH);
      clip_r.bottom <= 8'(SCREEN_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CLIP_LEFT:   clip_r.left   <= cfg_data;
        CFG_CLIP_TOP:    clip_r.top    <= cfg_data[7:0];
        CFG_CLIP_RIGHT:  clip_r.right  <= cfg_data;
        CFG_CLIP_BOTTOM: clip_r.bottom <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  grr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_kind       (in_kind),
    .in_char_code  (in_char_code),
    .in_char_index (in_char_index),
    .in_char_count (in_char_count),
    .in_origin_x   (in_origin_x),
    .in_origin_y   (in_origin_y),
    .in_scale      (in_scale),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .in_color      (in_color),
    .jq_push       (jq_push),
    .jq_din        (jq_din),
    .jq_full       (jq_full)
  );

  grr_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .din   (jq_din),
    .full  (jq_full),
    .pop   (jq_pop),
    .dout  (jq_dout),
    .empty (jq_empty)
  );

  grr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clip      (clip_r),
    .jq_dout   (jq_dout),
    .jq_empty  (jq_empty),
    .jq_pop    (jq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_rect  (out_rect)
  );

  assign out_x_start    = out_rect.x_start;
  assign out_y_start    = out_rect.y_start;
  assign out_x_end      = out_rect.x_end;
  assign out_y_end      = out_rect.y_end;
  assign out_fill_color = out_rect.fill_color;
  assign out_last       = out_rect.last;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the glyph rectangle renderer: its own glyph table and geometry model
// predict the clipped rectangles of every accepted character, and a monitor
// compares each popped rectangle against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import grr_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  code;
    logic [5:0]  idx;
    logic [6:0]  cnt;
    logic [10:0] ox;
    logic [10:0] oy;
    logic [3:0]  scale;
    logic [9:0]  bw;
    logic [9:0]  bh;
    logic [15:0] color;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0, in_full;
  logic in_kind = 1'b0;
  logic [7:0] in_char_code = '0;
  logic [5:0] in_char_index = '0;
  logic [6:0] in_char_count = '0;
  logic signed [10:0] in_origin_x = '0, in_origin_y = '0;
  logic [3:0] in_scale = '0;
  logic [9:0] in_box_width = '0, in_box_height = '0;
  logic [15:0] in_color = '0;
  logic out_empty, out_pop = 1'b0;
  logic [8:0] out_x_start, out_x_end;
  logic [7:0] out_y_start, out_y_end;
  logic [15:0] out_fill_color;
  logic out_last;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  glyph_rect_renderer dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_item_t pending_chars[$];
  rect_t      expected_rects[$];
  int         send_idle_pct = 0, pop_stall_pct = 0;
  bit         hold_send = 1'b0;
  int         errors = 0;
  int         cycle_count = 0;
  int         clip_l = 0, clip_t = 0, clip_r = SCREEN_WIDTH, clip_b = SCREEN_HEIGHT;

  function automatic logic [34:0] glyph_bits(input logic [7:0] c);
    logic [4:0] r[7];
    r = '{default: 5'd0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      case (c - 8'h41)
        0: r = '{14,17,17,31,17,17,17};  1: r = '{30,17,17,30,17,17,30};
        2: r = '{14,17,16,16,16,17,14};  3: r = '{30,17,17,17,17,17,30};
        4: r = '{31,16,16,30,16,16,31};  5: r = '{31,16,16,30,16,16,16};
        6: r = '{14,17,16,23,17,17,15};  7: r = '{17,17,17,31,17,17,17};
        8: r = '{14,4,4,4,4,4,14};       9: r = '{7,2,2,2,18,18,12};
        10: r = '{17,18,20,24,20,18,17}; 11: r = '{16,16,16,16,16,16,31};
        12: r = '{17,27,21,21,17,17,17}; 13: r = '{17,25,21,19,17,17,17};
        14: r = '{14,17,17,17,17,17,14}; 15: r = '{30,17,17,30,16,16,16};
        16: r = '{14,17,17,17,21,18,13}; 17: r = '{30,17,17,30,20,18,17};
        18: r = '{15,16,16,14,1,1,30};   19: r = '{31,4,4,4,4,4,4};
        20: r = '{17,17,17,17,17,17,14}; 21: r = '{17,17,17,17,17,10,4};
        22: r = '{17,17,17,21,21,21,10}; 23: r = '{17,17,10,4,10,17,17};
        24: r = '{17,17,10,4,4,4,4};     default: r = '{31,1,2,4,8,16,31};
      endcase
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      case (c - 8'h61)
        0: r = '{0,0,14,1,15,17,15};     1: r = '{16,16,30,17,17,17,30};
        2: r = '{0,0,14,16,16,17,14};    3: r = '{1,1,15,17,17,17,15};
        4: r = '{0,0,14,17,31,16,14};    5: r = '{6,9,8,28,8,8,8};
        6: r = '{0,0,15,17,15,1,14};     7: r = '{16,16,30,17,17,17,17};
        8: r = '{4,0,12,4,4,4,14};       9: r = '{2,0,6,2,2,18,12};
        10: r = '{16,16,18,20,24,20,18}; 11: r = '{12,4,4,4,4,4,14};
        12: r = '{0,0,26,21,21,21,21};   13: r = '{0,0,30,17,17,17,17};
        14: r = '{0,0,14,17,17,17,14};   15: r = '{0,0,30,17,30,16,16};
        16: r = '{0,0,15,17,15,1,1};     17: r = '{0,0,22,25,16,16,16};
        18: r = '{0,0,15,16,14,1,30};    19: r = '{8,8,28,8,8,9,6};
        20: r = '{0,0,17,17,17,19,13};   21: r = '{0,0,17,17,17,10,4};
        22: r = '{0,0,17,17,21,21,10};   23: r = '{0,0,17,10,4,10,17};
        24: r = '{0,0,17,17,15,1,14};    default: r = '{0,0,31,2,4,8,31};
      endcase
    end else if (c >= 8'h30 && c <= 8'h39) begin
      case (c - 8'h30)
        0: r = '{14,17,19,21,25,17,14}; 1: r = '{4,12,4,4,4,4,14};
        2: r = '{14,17,1,2,4,8,31};     3: r = '{30,1,1,14,1,1,30};
        4: r = '{2,6,10,18,31,2,2};     5: r = '{31,16,16,30,1,1,30};
        6: r = '{6,8,16,30,17,17,14};   7: r = '{31,1,2,4,8,8,8};
        8: r = '{14,17,17,14,17,17,14}; default: r = '{14,17,17,15,1,2,12};
      endcase
    end else begin
      case (c)
        "+": r = '{0,4,4,31,4,4,0};       "-": r = '{0,0,0,31,0,0,0};
        "=": r = '{0,0,31,0,31,0,0};      "*": r = '{0,17,10,4,10,17,0};
        "/": r = '{1,1,2,4,8,16,16};      8'h1F: r = '{4,0,0,31,0,0,4};
        8'h1E: r = '{0,31,10,10,10,10,18}; 8'h1D: r = '{0,15,18,18,18,12,0};
        8'h1A: r = '{0,4,2,31,2,4,0};     8'h1C: r = '{14,17,17,31,17,17,14};
        8'h1B: r = '{0,2,4,8,16,31,0};    ".": r = '{0,0,0,0,0,6,6};
        ",": r = '{0,0,0,0,0,6,4};        ":": r = '{0,4,4,0,4,4,0};
        ";": r = '{0,4,4,0,4,4,8};        "(": r = '{2,4,8,8,8,4,2};
        ")": r = '{8,4,2,2,2,4,8};        "[": r = '{14,8,8,8,8,8,14};
        "]": r = '{14,2,2,2,2,2,14};      "<": r = '{0,2,4,8,4,2,0};
        ">": r = '{0,8,4,2,4,8,0};        "^": r = '{4,10,17,0,0,0,0};
        "_": r = '{0,0,0,0,0,0,31};       "|": r = '{4,4,4,4,4,4,4};
        "!": r = '{4,4,4,4,0,4,0};        "?": r = '{14,17,2,4,0,4,0};
        8'h27: r = '{4,4,0,0,0,0,0};      8'h22: r = '{10,10,0,0,0,0,0};
        "%": r = '{25,26,2,4,8,11,19};    "&": r = '{12,18,20,8,21,18,13};
        " ": r = '{0,0,0,0,0,0,0};
        default: r = '{31,17,0,4,0,17,31};
      endcase
    end
    return {r[0], r[1], r[2], r[3], r[4], r[5], r[6]};
  endfunction

  function automatic void predict_rects(input char_item_t it);
    logic [34:0] g;
    int cr, cb, cnt, adv, gw, bx, x0, y0, x1, y1, n0;
    rect_t rc;
    cr = clip_r > SCREEN_WIDTH ? SCREEN_WIDTH : clip_r;
    cb = clip_b > SCREEN_HEIGHT ? SCREEN_HEIGHT : clip_b;
    cnt = it.cnt > MAX_STRING ? MAX_STRING : int'(it.cnt);
    adv = 0; gw = 0; bx = 0;
    if (it.kind) begin
      if (cnt == 0) return;
      adv = it.bw / cnt;
      if (adv > ADV_CAP) adv = ADV_CAP;
      gw = adv - 2 < 5 ? 5 : adv - 2;
      bx = $signed(it.ox) + (int'(it.bw) - (cnt * adv - 2)) / 2 + int'(it.idx) * adv;
    end
    g = glyph_bits(it.code);
    n0 = expected_rects.size();
    for (int r = 0; r < 7; r++)
      for (int c = 0; c < 5; c++) begin
        if (!g[34 - (r * 5 + c)]) continue;
        if (it.kind) begin
          x0 = bx + c * gw / 5;
          x1 = bx + (c + 1) * gw / 5;
          y0 = $signed(it.oy) + r * int'(it.bh) / 7;
          y1 = $signed(it.oy) + (r + 1) * int'(it.bh) / 7;
        end else begin
          x0 = $signed(it.ox) + int'(it.idx) * 6 * int'(it.scale) + c * int'(it.scale);
          x1 = x0 + int'(it.scale);
          y0 = $signed(it.oy) + r * int'(it.scale);
          y1 = y0 + int'(it.scale);
        end
        if (x0 < clip_l) x0 = clip_l;
        if (y0 < clip_t) y0 = clip_t;
        if (x1 > cr) x1 = cr;
        if (y1 > cb) y1 = cb;
        if (x0 >= x1 || y0 >= y1) continue;
        rc.x_start = x0[8:0]; rc.y_start = y0[7:0];
        rc.x_end = x1[8:0]; rc.y_end = y1[7:0];
        rc.fill_color = it.color; rc.last = 1'b0;
        expected_rects.push_back(rc);
      end
    if (expected_rects.size() > n0) expected_rects[$].last = 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_rects(pending_chars.pop_front());
      end
      if (in_push && in_full) begin
      end else if (pending_chars.size() > 0 && !hold_send &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_push <= 1'b1;
        in_kind <= pending_chars[0].kind;
        in_char_code <= pending_chars[0].code;
        in_char_index <= pending_chars[0].idx;
        in_char_count <= pending_chars[0].cnt;
        in_origin_x <= pending_chars[0].ox;
        in_origin_y <= pending_chars[0].oy;
        in_scale <= pending_chars[0].scale;
        in_box_width <= pending_chars[0].bw;
        in_box_height <= pending_chars[0].bh;
        in_color <= pending_chars[0].color;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rect_t exp_rc;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_rects.size() == 0) begin
          $error("rectangle with none expected: x %0d y %0d", out_x_start, out_y_start);
          errors++;
        end else begin
          exp_rc = expected_rects.pop_front();
          if (out_x_start !== exp_rc.x_start) begin
            $error("x_start exp %0d got %0d", exp_rc.x_start, out_x_start); errors++;
          end
          if (out_y_start !== exp_rc.y_start) begin
            $error("y_start exp %0d got %0d", exp_rc.y_start, out_y_start); errors++;
          end
          if (out_x_end !== exp_rc.x_end) begin
            $error("x_end exp %0d got %0d", exp_rc.x_end, out_x_end); errors++;
          end
          if (out_y_end !== exp_rc.y_end) begin
            $error("y_end exp %0d got %0d", exp_rc.y_end, out_y_end); errors++;
          end
          if (out_fill_color !== exp_rc.fill_color) begin
            $error("fill_color exp %0h got %0h", exp_rc.fill_color, out_fill_color);
            errors++;
          end
          if (out_last !== exp_rc.last) begin
            $error("last exp %0d got %0d", exp_rc.last, out_last); errors++;
          end
        end
      end
      out_pop <= $urandom_range(99) >= pop_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("tb failed");
      $finish;
    end
  end

  // characters with no rectangles can still sit in the front, job queue and
  // walker, so idle long enough for all of them to retire
  task automatic wait_drained();
    while (pending_chars.size() > 0 || in_push || expected_rects.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_clip(input logic [2:0] idx, input int val);
    cfg_index <= idx;
    cfg_data <= val[8:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CLIP_LEFT: clip_l = val[8:0];
      CFG_CLIP_TOP: clip_t = val[7:0];
      CFG_CLIP_RIGHT: clip_r = val[8:0];
      default: clip_b = val[7:0];
    endcase
  endtask

  task automatic set_window(input int l, input int t, input int r, input int b);
    write_clip(CFG_CLIP_LEFT, l);
    write_clip(CFG_CLIP_TOP, t);
    write_clip(CFG_CLIP_RIGHT, r);
    write_clip(CFG_CLIP_BOTTOM, b);
  endtask

  function automatic char_item_t make_char(input logic k, input logic [7:0] code,
      input int idx, input int cnt, input int ox, input int oy, input int sc,
      input int bw, input int bh, input logic [15:0] col);
    char_item_t it;
    it.kind = k; it.code = code; it.idx = idx[5:0]; it.cnt = cnt[6:0];
    it.ox = ox[10:0]; it.oy = oy[10:0]; it.scale = sc[3:0];
    it.bw = bw[9:0]; it.bh = bh[9:0]; it.color = col;
    return it;
  endfunction

  // mostly strings that land on screen, some wild noise
  task automatic queue_random(input int count);
    char_item_t it;
    int len, k, ox, oy, sc, bw, bh;
    logic [15:0] col;
    while (count > 0) begin
      len = $urandom_range(1, 8);
      k = $urandom_range(1);
      ox = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) - 1024
                                     : $urandom_range(0, 400) - 40;
      oy = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) - 1024
                                     : $urandom_range(0, 240) - 20;
      sc = $urandom_range(0, 15);
      bw = $urandom_range(0, 5) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 200);
      bh = $urandom_range(0, 5) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 120);
      col = $urandom;
      for (int i = 0; i < len && count > 0; i++) begin
        it = make_char(k, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                    : $urandom_range(32, 126),
                       i, len, ox, oy, sc, bw, bh, col);
        if ($urandom_range(0, 9) == 0) begin
          it.idx = $urandom;
          it.cnt = $urandom;
        end
        pending_chars.push_back(it);
        count--;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: glyph classes, extremes and special cases
    pending_chars.push_back(make_char(0, "A", 0, 1, 0, 0, 2, 0, 0, 16'h0000));
    pending_chars.push_back(make_char(0, "8", 1, 1, 10, 20, 3, 0, 0, 16'hFFFF));
    pending_chars.push_back(make_char(0, " ", 2, 1, 10, 20, 3, 0, 0, 16'h1234));
    pending_chars.push_back(make_char(0, 8'hFF, 0, 1, 100, 50, 15, 0, 0, 16'hA5A5));
    pending_chars.push_back(make_char(0, 8'h00, 3, 1, 5, 5, 1, 0, 0, 16'h5A5A));
    pending_chars.push_back(make_char(0, "W", 0, 1, 20, 20, 0, 0, 0, 16'h0F0F));
    pending_chars.push_back(make_char(0, 8'h1F, 63, 1, -1024, -1024, 15, 1023, 1023,
                                      16'hF0F0));
    pending_chars.push_back(make_char(0, "%", 0, 1, 1023, 1023, 15, 0, 0, 16'h8001));
    pending_chars.push_back(make_char(0, "&", 0, 1, -10, -10, 8, 0, 0, 16'h7FFE));
    pending_chars.push_back(make_char(1, "g", 0, 5, 10, 10, 0, 100, 70, 16'h00FF));
    pending_chars.push_back(make_char(1, "H", 4, 5, 10, 10, 0, 100, 70, 16'hFF00));
    pending_chars.push_back(make_char(1, "H", 0, 0, 10, 10, 0, 100, 70, 16'h1111));
    pending_chars.push_back(make_char(1, "1", 70, 127, 0, 0, 0, 1023, 1023, 16'h2222));
    pending_chars.push_back(make_char(1, "?", 10, 3, 0, 0, 0, 30, 21, 16'h3333));
    pending_chars.push_back(make_char(1, "M", 0, 1, 0, 0, 0, 0, 0, 16'h4444));
    pending_chars.push_back(make_char(1, 8'h80, 0, 64, -1024, 0, 0, 1023, 300,
                                      16'h5555));
    pending_chars.push_back(make_char(1, "z", 2, 4, 300, 150, 0, 40, 35, 16'h6666));
    wait_drained();

    set_window(50, 30, 200, 120);
    pending_chars.push_back(make_char(0, "B", 0, 1, 40, 20, 15, 0, 0, 16'h7777));
    pending_chars.push_back(make_char(1, "Q", 0, 2, 40, 20, 0, 300, 200, 16'h8888));
    queue_random(40);
    wait_drained();

    set_window(511, 255, 511, 255);   // right/bottom saturate, window empty
    pending_chars.push_back(make_char(0, "O", 0, 1, 0, 0, 4, 0, 0, 16'h9999));
    wait_drained();
    set_window(0, 0, 0, 0);
    queue_random(10);
    wait_drained();
    set_window(0, 0, 511, 255);
    queue_random(60);
    wait_drained();

    // sender waits for the block to drain between batches
    set_window(0, 0, SCREEN_WIDTH, SCREEN_HEIGHT);
    send_idle_pct = 75;
    queue_random(40);
    wait_drained();
    send_idle_pct = 0; pop_stall_pct = 75;
    queue_random(40);
    hold_send = 1'b1;
    repeat (200) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();
    set_window(17, 9, 300, 180);
    send_idle_pct = 12; pop_stall_pct = 12;
    queue_random(60);
    wait_drained();
    send_idle_pct = 0; pop_stall_pct = 0;
    set_window(100, 100, 101, 101);
    queue_random(40);
    wait_drained();

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
